/* hw/rtl/rds_pkg.sv */
package rds_pkg;

  localparam int QueueDepth = 8;
  localparam int MaxPayload = 1024;
  localparam int SeqBits    = 16;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0, ACT_CONNECT = 2'd1, ACT_SEND = 2'd2, ACT_RX = 2'd3
  } act_t;

  localparam logic [2:0] RX_SYN  = 3'd0;
  localparam logic [2:0] RX_ACK  = 3'd1;
  localparam logic [2:0] RX_DATA = 3'd2;

  localparam logic [2:0] TX_NONE = 3'd0;
  localparam logic [2:0] TX_SYN  = 3'd1;
  localparam logic [2:0] TX_DATA = 3'd2;
  localparam logic [2:0] TX_ACK  = 3'd3;
  localparam logic [2:0] TX_PING = 3'd4;

  localparam logic [1:0] M_CLOSED  = 2'd0;
  localparam logic [1:0] M_OPENING = 2'd1;
  localparam logic [1:0] M_OPEN    = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CONNECTED = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_LOST      = 3'd4;
  localparam logic [2:0] ST_RETRIES   = 3'd5;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_PING    = 3'd1;
  localparam logic [2:0] REG_RETRY   = 3'd2;
  localparam logic [2:0] REG_PING_ON = 3'd3;
  localparam logic [2:0] REG_FIRST   = 3'd4;

  // classified item between front and back
  typedef struct packed {
    act_t        act;
    logic [2:0]  kind;
    logic [15:0] rseq;
    logic [10:0] plen;
    logic [15:0] psum;
    logic        too_long;
  } item_t;

  // one result with its per-input fields
  typedef struct packed {
    logic [2:0]  tx_kind;
    logic [15:0] tx_seq;
    logic [2:0]  tx_slot;
    logic [10:0] tx_len;
    logic [15:0] tx_sum;
    logic        deliver;
    logic [1:0]  session_mode;
    logic [2:0]  status;
    logic        last;
  } res_t;

endpackage

/* hw/rtl/rds_front.sv */
module rds_front #(
  parameter int MAX_PAYLOAD = rds_pkg::MaxPayload
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [47:0]   in_data,
  output logic          q_valid,
  input  logic          q_ready,
  output rds_pkg::item_t q_item
);
  import rds_pkg::*;

  // two-entry queue decouples intake from the session engine
  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  item_t      it;
  logic       push, pop;

  always_comb begin
    it.act      = act_t'(in_data[1:0]);
    it.kind     = in_data[4:2];
    it.rseq     = in_data[20:5];
    it.plen     = in_data[31:21];
    it.psum     = in_data[47:32];
    it.too_long = 32'(in_data[31:21]) > 32'(MAX_PAYLOAD);
  end

  assign in_ready = cnt != 2'd2;
  assign q_valid  = cnt != 2'd0;
  assign q_item   = mem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= it;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hw/rtl/rds_back.sv */
module rds_back #(
  parameter int QUEUE_DEPTH = rds_pkg::QueueDepth,
  parameter int SEQ_BITS    = rds_pkg::SeqBits
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  rds_pkg::item_t q_item,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rds_pkg::res_t  out_res
);
  import rds_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [15:0] timeout_ms, ping_ms;
  logic [7:0]  retry_limit;
  logic        ping_on;
  logic [1:0]  mode;
  logic [SEQ_BITS-1:0] next_seq, peer_seq;
  logic        peer_known;
  logic [31:0] now_ms, ping_at, heard_at;
  logic [PW-1:0] head, tail;
  logic [PW:0]   fill;

  logic        s_data [QUEUE_DEPTH];
  logic [SEQ_BITS-1:0] s_seq [QUEUE_DEPTH];
  logic [10:0] s_len [QUEUE_DEPTH];
  logic [15:0] s_sum [QUEUE_DEPTH];
  logic [7:0]  s_tries [QUEUE_DEPTH];
  logic [31:0] s_at [QUEUE_DEPTH];

  // two-entry result buffer
  res_t        ob [2];
  logic        ob_v [2];

  logic [1:0]  mode_next;
  logic [SEQ_BITS-1:0] next_seq_next, peer_seq_next, rseq;
  logic        peer_known_next;
  logic [31:0] now_ms_next, ping_at_next, heard_at_next, tick;
  logic [PW-1:0] head_next, tail_next;
  logic [PW:0]   fill_next;
  logic        do_enq, is_data_enq, resend, bump;
  res_t        r0, r1;
  logic        n0, n1;
  logic [2:0]  status;
  logic        ping_fire, lost;
  logic [17:0] ping3;
  logic [SEQ_BITS-1:0] ack_seq;
  logic        dlv, ack_out;

  assign q_ready   = !ob_v[0] || (out_ready && !ob_v[1]);
  assign out_valid = ob_v[0];
  assign out_res   = ob[0];
  assign rseq      = SEQ_BITS'(q_item.rseq);
  assign tick      = now_ms + 32'd1;
  assign ping3     = {2'b0, ping_ms} + {1'b0, ping_ms, 1'b0};

  always_comb begin
    mode_next = mode;
    next_seq_next = next_seq;
    peer_seq_next = peer_seq;
    peer_known_next = peer_known;
    now_ms_next = now_ms;
    ping_at_next = ping_at;
    heard_at_next = heard_at;
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    do_enq = 1'b0;
    is_data_enq = 1'b0;
    resend = 1'b0;
    bump = 1'b0;
    status = ST_OK;
    ping_fire = 1'b0;
    lost = 1'b0;
    ack_out = 1'b0;
    dlv = 1'b0;
    ack_seq = rseq + SEQ_BITS'(1);
    case (q_item.act)
      ACT_TICK: begin
        now_ms_next = tick;
        if (ping_on && mode == M_OPEN) begin
          if (tick - ping_at > {16'd0, ping_ms}) begin
            ping_at_next = tick;
            ping_fire = 1'b1;
          end
          if (tick - heard_at > {14'd0, ping3}) begin
            ping_at_next = tick;
            mode_next = M_CLOSED;
            status = ST_LOST;
            lost = 1'b1;
          end
        end
        if (!lost && fill != '0) begin
          if (s_tries[head] > retry_limit) begin
            mode_next = M_CLOSED;
            fill_next = '0;
            tail_next = head;
            status = ST_RETRIES;
          end else if (tick - s_at[head] > {16'd0, timeout_ms} || s_tries[head] == 8'd0) begin
            resend = 1'b1;
            bump = s_tries[head] != 8'hff;
          end
        end
      end
      ACT_CONNECT: begin
        if (mode != M_CLOSED) status = ST_CONNECTED;
        else if (fill == (PW+1)'(QUEUE_DEPTH)) status = ST_FULL;
        else begin
          do_enq = 1'b1;
          mode_next = M_OPENING;
        end
      end
      ACT_SEND: begin
        if (q_item.too_long) status = ST_TOO_LONG;
        else if (fill == (PW+1)'(QUEUE_DEPTH)) status = ST_FULL;
        else begin
          do_enq = 1'b1;
          is_data_enq = 1'b1;
        end
      end
      default: begin
        heard_at_next = now_ms;
        if (q_item.kind == RX_SYN) begin
          mode_next = M_OPEN;
          peer_seq_next = rseq;
          ack_out = 1'b1;
        end else if (q_item.kind == RX_DATA) begin
          if (mode == M_OPEN) begin
            peer_known_next = 1'b1;
            dlv = peer_known ? (peer_seq + SEQ_BITS'(2) == rseq) : 1'b1;
            peer_seq_next = rseq;
            ack_out = 1'b1;
          end
        end else if (q_item.kind == RX_ACK) begin
          if (fill != '0 && s_seq[head] + SEQ_BITS'(1) == rseq) begin
            if (mode == M_OPENING) mode_next = M_OPEN;
            head_next = (head == PW'(QUEUE_DEPTH-1)) ? '0 : head + PW'(1);
            fill_next = fill - (PW+1)'(1);
          end
        end
      end
    endcase
    if (do_enq) begin
      next_seq_next = next_seq + SEQ_BITS'(2);
      tail_next = (tail == PW'(QUEUE_DEPTH-1)) ? '0 : tail + PW'(1);
      fill_next = fill + (PW+1)'(1);
    end
    // build up to two results
    r0 = '0;
    r1 = '0;
    n1 = 1'b0;
    if (ping_fire) r0.tx_kind = TX_PING;
    else if (ack_out) begin
      r0.tx_kind = TX_ACK;
      r0.tx_seq = 16'(ack_seq);
      r0.deliver = dlv;
    end
    r1.tx_kind = s_data[head] ? TX_DATA : TX_SYN;
    r1.tx_seq  = 16'(s_seq[head]);
    r1.tx_slot = 3'(head);
    r1.tx_len  = s_data[head] ? s_len[head] : 11'd0;
    r1.tx_sum  = s_data[head] ? s_sum[head] : 16'd0;
    if (resend) begin
      if (ping_fire) n1 = 1'b1;
      else begin
        r0 = r1;
      end
    end
    n0 = 1'b1;
    r0.session_mode = mode_next;
    r0.status = status;
    r0.last = !n1;
    r1.session_mode = mode_next;
    r1.status = status;
    r1.last = 1'b1;
  end

  logic take, pop;
  assign take = q_valid && q_ready;
  assign pop  = ob_v[0] && out_ready;

  always_ff @(posedge clk) begin
    if (take && do_enq) begin
      s_data[tail]  <= is_data_enq;
      s_seq[tail]   <= next_seq;
      s_len[tail]   <= q_item.plen;
      s_sum[tail]   <= q_item.psum;
      s_tries[tail] <= 8'd0;
      s_at[tail]    <= now_ms;
    end
    if (take && resend) begin
      if (bump) s_tries[head] <= s_tries[head] + 8'd1;
      s_at[head] <= tick;
    end
    // output buffer: a new input refills it, otherwise shift on pop
    if (take) begin
      if (!ob_v[0] || (pop && !ob_v[1])) begin
        ob[0] <= r0;
        ob[1] <= r1;
      end
    end else if (pop) begin
      ob[0] <= ob[1];
    end
    if (rst) begin
      timeout_ms <= 16'd100;
      ping_ms <= 16'd1000;
      retry_limit <= 8'd5;
      ping_on <= 1'b1;
      mode <= M_CLOSED;
      next_seq <= '0;
      peer_seq <= '0;
      peer_known <= 1'b0;
      now_ms <= '0;
      ping_at <= '0;
      heard_at <= '0;
      head <= '0;
      tail <= '0;
      fill <= '0;
      ob_v[0] <= 1'b0;
      ob_v[1] <= 1'b0;
    end else begin
      if (take) begin
        ob_v[0] <= n0;
        ob_v[1] <= n1;
        mode <= mode_next;
        next_seq <= next_seq_next;
        peer_seq <= peer_seq_next;
        peer_known <= peer_known_next;
        now_ms <= now_ms_next;
        ping_at <= ping_at_next;
        heard_at <= heard_at_next;
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end else if (pop) begin
        ob_v[0] <= ob_v[1];
        ob_v[1] <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_ms <= cfg_data;
          REG_PING:    ping_ms <= cfg_data;
          REG_RETRY:   retry_limit <= cfg_data[7:0];
          REG_PING_ON: ping_on <= cfg_data[0];
          REG_FIRST:   next_seq <= SEQ_BITS'({6'd0, cfg_data[9:0]});
          default: ;
        endcase
      end
    end
  end
endmodule

/* hw/rtl/reliable_datagram_session_core.sv */
// channel   | direction | payload
// s_axis    | in        | tdata: action, rx_kind, rx_seq, payload_len, payload_sum
// m_axis    | out       | tdata: result fields; tlast: final result of an input
// cfg       | in        | write enable, register index, 16-bit data
//
// an input is registered in the front queue and then in the result buffer
// before its first result is offered; a tick with ping plus resend makes two
// results and holds the engine while the two-entry result buffer drains, so
// no new input is taken until the second result is being popped.
// rst is synchronous and clears all session state; queue slots are left
// undefined until written. either side may stall without loss.
module reliable_datagram_session_core #(
  parameter int QUEUE_DEPTH = rds_pkg::QueueDepth,
  parameter int MAX_PAYLOAD = rds_pkg::MaxPayload,
  parameter int SEQ_BITS    = rds_pkg::SeqBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // action[1:0], rx_kind[4:2], rx_seq[20:5], payload_len[31:21], payload_sum[47:32]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tx_kind[2:0], tx_seq[18:3], tx_slot[21:19], tx_len[32:22], tx_sum[48:33],
  // deliver[49], session_mode[51:50], status[54:52]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rds_pkg::*;

  logic  q_valid, q_ready;
  item_t q_item;
  res_t  res;

  // front: intake and classification
  rds_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .q_valid, .q_ready, .q_item
  );

  // back: session engine and result buffer
  rds_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .SEQ_BITS(SEQ_BITS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.session_mode, res.deliver, res.tx_sum,
                         res.tx_len, res.tx_slot, res.tx_seq, res.tx_kind};
  assign m_axis_tlast = res.last;
endmodule

/* tb/reliable_datagram_session_core_tb.sv */
module reliable_datagram_session_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  // session predictor plus the store of expected transmit results
  class session_scoreboard;
    res_t        expected_tx[$];
    res_t        step_out[$];
    int          errors;
    logic [15:0] resend_ms, ping_ms;
    logic [7:0]  retry_max;
    logic        ping_en;
    logic [1:0]  mode;
    logic [15:0] next_seq, peer_seq;
    logic        peer_known;
    logic [31:0] now_ms, ping_at, heard_at;
    logic        q_data[QueueDepth];
    logic [15:0] q_seq[QueueDepth];
    logic [10:0] q_len[QueueDepth];
    logic [15:0] q_sum[QueueDepth];
    logic [7:0]  q_tries[QueueDepth];
    logic [31:0] q_sent[QueueDepth];
    logic [2:0]  head, tail;
    int          fill;

    function new();
      errors = 0;
      resend_ms = 100;
      ping_ms = 1000;
      retry_max = 5;
      ping_en = 1'b1;
      mode = M_CLOSED;
      next_seq = 0;
      peer_seq = 0;
      peer_known = 1'b0;
      now_ms = 0;
      ping_at = 0;
      heard_at = 0;
      head = 0;
      tail = 0;
      fill = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        REG_TIMEOUT: resend_ms = v;
        REG_PING:    ping_ms = v;
        REG_RETRY:   retry_max = v[7:0];
        REG_PING_ON: ping_en = v[0];
        REG_FIRST: begin
          next_seq = {6'd0, v[9:0]};
        end
        default: ;
      endcase
    endfunction

    function void emit(logic [2:0] k, logic [15:0] s, logic [2:0] sl, logic [10:0] l,
                       logic [15:0] cs, logic d);
      res_t r;
      r = '0;
      r.tx_kind = k;
      r.tx_seq = s;
      r.tx_slot = sl;
      r.tx_len = l;
      r.tx_sum = cs;
      r.deliver = d;
      step_out.push_back(r);
    endfunction

    function bit enqueue(logic is_data, logic [10:0] l, logic [15:0] cs);
      if (fill >= QueueDepth) return 0;
      q_data[tail] = is_data;
      q_seq[tail] = next_seq;
      q_len[tail] = l;
      q_sum[tail] = cs;
      q_tries[tail] = 0;
      q_sent[tail] = now_ms;
      next_seq = next_seq + 16'd2;
      tail = tail + 3'd1;
      fill++;
      return 1;
    endfunction

    // one accepted input: advance the session and queue its results
    function void note_item(logic [47:0] d);
      act_t        a;
      logic [2:0]  k, st;
      logic [15:0] rs;
      logic [10:0] pl;
      logic [15:0] ps;
      bit          stop;
      res_t        r;
      a = act_t'(d[1:0]);
      k = d[4:2];
      rs = d[20:5];
      pl = d[31:21];
      ps = d[47:32];
      st = ST_OK;
      stop = 0;
      step_out.delete();
      case (a)
        ACT_TICK: begin
          now_ms = now_ms + 1;
          if (ping_en && mode == M_OPEN) begin
            if (now_ms - ping_at > {16'd0, ping_ms}) begin
              ping_at = now_ms;
              emit(TX_PING, 0, 0, 0, 0, 0);
            end
            if (now_ms - heard_at > 32'd3 * {16'd0, ping_ms}) begin
              ping_at = now_ms;
              mode = M_CLOSED;
              st = ST_LOST;
              stop = 1;
            end
          end
          if (!stop && fill > 0) begin
            if (q_tries[head] > retry_max) begin
              // retries used up: drop the whole queue
              mode = M_CLOSED;
              fill = 0;
              tail = head;
              st = ST_RETRIES;
            end else if (now_ms - q_sent[head] > {16'd0, resend_ms} || q_tries[head] == 0) begin
              if (q_tries[head] != 8'hff) q_tries[head]++;
              q_sent[head] = now_ms;
              if (q_data[head])
                emit(TX_DATA, q_seq[head], head, q_len[head], q_sum[head], 0);
              else
                emit(TX_SYN, q_seq[head], head, 0, 0, 0);
            end
          end
        end
        ACT_CONNECT: begin
          if (mode != M_CLOSED) st = ST_CONNECTED;
          else if (!enqueue(1'b0, 0, 0)) st = ST_FULL;
          else mode = M_OPENING;
        end
        ACT_SEND: begin
          if (pl > MaxPayload) st = ST_TOO_LONG;
          else if (!enqueue(1'b1, pl, ps)) st = ST_FULL;
        end
        default: begin
          heard_at = now_ms;
          if (k == RX_SYN) begin
            mode = M_OPEN;
            peer_seq = rs;
            emit(TX_ACK, rs + 16'd1, 0, 0, 0, 0);
          end else if (k == RX_DATA) begin
            if (mode == M_OPEN) begin
              if (!peer_known) begin
                peer_known = 1'b1;
                peer_seq = rs - 16'd2;
              end
              emit(TX_ACK, rs + 16'd1, 0, 0, 0, (peer_seq + 16'd2) == rs);
              peer_seq = rs;
            end
          end else if (k == RX_ACK) begin
            if (fill > 0 && q_seq[head] + 16'd1 == rs) begin
              if (mode == M_OPENING) mode = M_OPEN;
              head = head + 3'd1;
              fill--;
            end
          end
        end
      endcase
      if (step_out.size() == 0) emit(TX_NONE, 0, 0, 0, 0, 0);
      foreach (step_out[i]) begin
        r = step_out[i];
        r.session_mode = mode;
        r.status = st;
        r.last = (i == step_out.size() - 1);
        expected_tx.push_back(r);
      end
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(res_t got);
      res_t w;
      if (expected_tx.size() == 0) begin
        report("unexpected result", 32'(got.tx_kind), 0);
        return;
      end
      w = expected_tx.pop_front();
      if (got.tx_kind != w.tx_kind) report("tx_kind", 32'(got.tx_kind), 32'(w.tx_kind));
      if (got.tx_seq != w.tx_seq) report("tx_seq", 32'(got.tx_seq), 32'(w.tx_seq));
      if (got.tx_slot != w.tx_slot) report("tx_slot", 32'(got.tx_slot), 32'(w.tx_slot));
      if (got.tx_len != w.tx_len) report("tx_len", 32'(got.tx_len), 32'(w.tx_len));
      if (got.tx_sum != w.tx_sum) report("tx_sum", 32'(got.tx_sum), 32'(w.tx_sum));
      if (got.deliver != w.deliver) report("deliver", 32'(got.deliver), 32'(w.deliver));
      if (got.session_mode != w.session_mode)
        report("session_mode", 32'(got.session_mode), 32'(w.session_mode));
      if (got.status != w.status) report("status", 32'(got.status), 32'(w.status));
      if (got.last != w.last) report("last", 32'(got.last), 32'(w.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  session_scoreboard sb = new();
  bit no_idle = 0;     // phase without any gaps on either side
  bit finished = 0;
  int quiet = 0;       // cycles with no transaction at all

  always #5 clk = ~clk;

  reliable_datagram_session_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic [47:0] pack_item(act_t a, logic [2:0] k, logic [15:0] s,
                                            logic [10:0] l, logic [15:0] cs);
    return {cs, l, s, k, a};
  endfunction

  // ack carrying the number the head frame waits for
  function automatic logic [47:0] head_ack();
    return pack_item(ACT_RX, RX_ACK, sb.q_seq[sb.head] + 16'd1, 0, 0);
  endfunction

  // random item, biased towards sequences that open the session and move the queue
  function automatic logic [47:0] random_item();
    int          r;
    logic [2:0]  rk;
    logic [15:0] rs, rc;
    logic [10:0] rl;
    r = $urandom_range(0, 99);
    rk = 3'($urandom);
    rs = 16'($urandom);
    rl = 11'($urandom);
    rc = 16'($urandom);
    if (r < 40) return pack_item(ACT_TICK, rk, rs, rl, rc);
    if (r < 48) return pack_item(ACT_CONNECT, rk, rs, rl, rc);
    if (r < 63) begin
      if ($urandom_range(0, 9) == 0)
        return pack_item(ACT_SEND, rk, rs, 11'($urandom_range(1025, 2047)), rc);
      return pack_item(ACT_SEND, rk, rs, 11'($urandom_range(0, 1024)), rc);
    end
    if (r < 78) begin
      if (sb.fill > 0 && $urandom_range(0, 4) != 0) return head_ack();
      return pack_item(ACT_RX, RX_ACK, rs, rl, rc);
    end
    if (r < 85) return pack_item(ACT_RX, RX_SYN, rs, rl, rc);
    if (r < 93) begin
      if ($urandom_range(0, 9) < 7)
        return pack_item(ACT_RX, RX_DATA, sb.peer_seq + 16'd2, rl, rc);
      return pack_item(ACT_RX, RX_DATA, rs, rl, rc);
    end
    return pack_item(ACT_RX, 3'($urandom_range(3, 7)), rs, rl, rc);
  endfunction

  // offer one item after a random gap; notes it once the transaction is taken
  task automatic drive_item(logic [47:0] d);
    int  gap;
    bit  taken;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end while (!taken);
    sb.note_item(d);
  endtask

  task automatic drive_random(int n);
    repeat (n) drive_item(random_item());
  endtask

  // wait for the block to drain, then load all five registers
  task automatic load_config(logic [15:0] tmo, logic [15:0] per, logic [7:0] rl,
                             logic on, logic [9:0] fs);
    logic [15:0] vals[5];
    vals = '{tmo, per, {8'd0, rl}, {15'd0, on}, {6'd0, fs}};
    s_axis_tvalid <= 1'b0;
    while (sb.expected_tx.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.write_reg(i[2:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin
    int   gap, seen;
    bit   got_v;
    res_t got;
    seen = 0;
    @(negedge rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (seen == 300) gap = 400;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        got_v = m_axis_tvalid;
        got = {m_axis_tdata[2:0], m_axis_tdata[18:3], m_axis_tdata[21:19],
               m_axis_tdata[32:22], m_axis_tdata[48:33], m_axis_tdata[49],
               m_axis_tdata[51:50], m_axis_tdata[54:52], m_axis_tlast};
        @(posedge clk);
      end while (!got_v);
      sb.check_result(got);
      seen++;
    end
  end

  // watchdog on cycles without any transaction
  always @(negedge clk) begin
    if (!rst && !finished) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet > 3000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: tight timers so the special cases show up quickly
    load_config(3, 4, 2, 1, 0);
    drive_item(pack_item(ACT_CONNECT, 0, 0, 0, 0));
    drive_item(pack_item(ACT_CONNECT, 0, 0, 0, 0));             // already connected
    drive_item(pack_item(ACT_SEND, 0, 0, 0, 0));
    drive_item(pack_item(ACT_SEND, 0, 0, 1024, 16'hffff));
    drive_item(pack_item(ACT_SEND, 0, 0, 1025, 0));             // too long
    drive_item(pack_item(ACT_SEND, 0, 0, 11'h7ff, 0));
    drive_item(pack_item(ACT_TICK, 0, 0, 0, 0));                // syn goes out
    drive_item(pack_item(ACT_RX, RX_ACK, 16'h1234, 0, 0));      // wrong number
    drive_item(head_ack());                                     // opening to open
    drive_item(pack_item(ACT_RX, RX_DATA, 16'd10, 0, 0));       // first data, delivered
    drive_item(pack_item(ACT_RX, RX_DATA, 16'd40, 0, 0));       // out of order
    drive_item(pack_item(ACT_RX, RX_SYN, 16'hffff, 0, 0));      // ack number wraps
    for (int k = 3; k < 8; k++) drive_item(pack_item(ACT_RX, 3'(k), 16'hffff, 0, 0));
    repeat (7) drive_item(pack_item(ACT_SEND, 0, 0, 5, 16'h00a5));  // last one finds it full
    drive_random(170);

    load_config(1, 1, 0, 1, 999);
    drive_random(190);
    load_config(16'hffff, 16'hffff, 8'hff, 0, 512);
    drive_random(190);
    no_idle = 1;
    load_config(5, 12, 3, 1, 7);
    drive_random(190);
    no_idle = 0;
    load_config(20, 6, 8'hff, 1, 1);
    drive_random(190);
    load_config(2, 30, 1, 0, 300);
    drive_random(190);

    s_axis_tvalid <= 1'b0;
    while (sb.expected_tx.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    finished = 1;
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
